// ===== design/eqs_pkg.sv =====
package eqs_pkg;

   localparam int DATA_WIDTH = 24;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_WIDTH  = 32;
   localparam int REG_WIDTH  = 24;
   localparam int NUM_LANES  = 4;

   localparam int FRONT_STAGES = 8;
   localparam int DIV_STEPS    = 34;
   localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 1;

   localparam int DMAG_W = 48;
   localparam int QUO_W  = DIV_STEPS;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAME_LAMBDA   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHEAR_MODULUS = 1'd1;
   localparam logic [REG_WIDTH-1:0] REG_ONE = 24'd65536;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] grad_00;
      logic signed [DATA_WIDTH-1:0] grad_01;
      logic signed [DATA_WIDTH-1:0] grad_10;
      logic signed [DATA_WIDTH-1:0] grad_11;
      logic signed [DATA_WIDTH-1:0] jac_00;
      logic signed [DATA_WIDTH-1:0] jac_01;
      logic signed [DATA_WIDTH-1:0] jac_10;
      logic signed [DATA_WIDTH-1:0] jac_11;
      logic [REG_WIDTH-1:0]         quad_weight;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] res_00;
      logic signed [OUT_WIDTH-1:0] res_01;
      logic signed [OUT_WIDTH-1:0] res_10;
      logic signed [OUT_WIDTH-1:0] res_11;
      logic                        singular_flag;
      logic                        overflow_flag;
   } rsp_payload_type;

   typedef struct packed {
      logic                        hit;
      logic signed [OUT_WIDTH-1:0] val;
   } sat_type;

   // one division pipeline slot: shared divisor, four lanes
   typedef struct packed {
      logic                                singular;
      logic                                sat;
      logic [DMAG_W-1:0]                   dmag;
      logic [NUM_LANES-1:0]                neg;
      logic [NUM_LANES-1:0]                big;
      logic [NUM_LANES-1:0]                lsb;
      logic [NUM_LANES-1:0][DMAG_W-1:0]    rem;
      logic [NUM_LANES-1:0][QUO_W-1:0]     quo;
   } div_type;

   // add half an LSB, floor to FRAC_BITS, clamp to 32 bits
   function automatic sat_type rnd_sat(input logic signed [63:0] x);
      logic signed [63:0] r;
      sat_type o;
      r = (x >>> FRAC_BITS) + $signed({63'd0, x[FRAC_BITS-1]});
      o.hit = 1'b0;
      o.val = r[OUT_WIDTH-1:0];
      if (r > SAT_MAX) begin
         o.hit = 1'b1;
         o.val = SAT_MAX[OUT_WIDTH-1:0];
      end else if (r < SAT_MIN) begin
         o.hit = 1'b1;
         o.val = SAT_MIN[OUT_WIDTH-1:0];
      end
      return o;
   endfunction

endpackage

// ===== design/eqs_front.sv =====
module eqs_front import eqs_pkg::*; (
   input  logic                     clock,
   input  logic [FRONT_STAGES-1:0]  en,
   input  req_payload_type          req,
   input  logic [REG_WIDTH-1:0]     lam,
   input  logic [REG_WIDTH-1:0]     mu,
   output div_type                  dout
);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] j00;
      logic signed [DATA_WIDTH-1:0] j01;
      logic signed [DATA_WIDTH-1:0] j10;
      logic signed [DATA_WIDTH-1:0] j11;
      logic [REG_WIDTH-1:0]         w;
   } jw_type;

   typedef struct packed {
      logic signed [48:0] det;
      logic               sing;
      logic               sat;
   } ctl_type;

   jw_type             jw_ff [FRONT_STAGES-1];
   ctl_type            ctl_ff [FRONT_STAGES-1];
   logic signed [47:0] pa_ff, pb_ff;
   logic signed [47:0] pr_ff [8];
   logic signed [31:0] p_ff [4];
   logic signed [57:0] lt_ff, m0_ff, m1_ff;
   logic signed [58:0] m2_ff;
   logic signed [31:0] s00_ff, s01_ff, s11_ff;
   logic signed [55:0] sq_ff [8];
   logic signed [31:0] q_ff [4];
   logic signed [56:0] wqp_ff [4];
   div_type            dout_ff;

   sat_type            p_in [4];
   sat_type            s00_in, s01_in, s11_in;
   sat_type            q_in [4];
   sat_type            wq_in [4];
   logic signed [32:0] tr_in;
   logic signed [33:0] e01_sum;
   logic signed [32:0] e01_in;
   logic signed [24:0] lam_s;
   logic signed [25:0] mu2_s;
   logic signed [24:0] w_s;
   div_type            dout_in;

   always_comb begin
      logic signed [32:0] wx;
      logic [31:0]        nmag;
      logic [48:0]        dabs;
      for (int k = 0; k < 4; k++) begin
         p_in[k] = rnd_sat(64'(pr_ff[2*k]) - 64'(pr_ff[2*k+1]));
      end
      tr_in   = 33'(p_ff[0]) + 33'(p_ff[3]);
      e01_sum = 34'(p_ff[1]) + 34'(p_ff[2]) + 34'sd1;
      e01_in  = e01_sum[33:1];
      lam_s   = $signed({1'b0, lam});
      mu2_s   = $signed({1'b0, mu, 1'b0});
      s00_in  = rnd_sat(64'(lt_ff) + 64'(m0_ff));
      s11_in  = rnd_sat(64'(lt_ff) + 64'(m1_ff));
      s01_in  = rnd_sat(64'(m2_ff));
      for (int k = 0; k < 4; k++) begin
         q_in[k] = rnd_sat(64'(sq_ff[2*k]) - 64'(sq_ff[2*k+1]));
      end
      w_s = $signed({1'b0, jw_ff[5].w});
      for (int k = 0; k < 4; k++) begin
         wq_in[k] = rnd_sat(64'(wqp_ff[k]));
      end
      dabs = ctl_ff[6].det[48] ? 49'(-ctl_ff[6].det) : ctl_ff[6].det;
      dout_in.singular = ctl_ff[6].sing;
      dout_in.dmag     = dabs[DMAG_W-1:0];
      dout_in.sat      = ctl_ff[6].sat | wq_in[0].hit | wq_in[1].hit | wq_in[2].hit
                         | wq_in[3].hit;
      for (int k = 0; k < NUM_LANES; k++) begin
         wx   = 33'(wq_in[k].val);
         nmag = wx[32] ? 32'(-wx) : wx[31:0];
         dout_in.neg[k] = (nmag != 32'd0) && (wq_in[k].val[31] != ctl_ff[6].det[48]);
         dout_in.big[k] = {17'd0, nmag} >= {dout_in.dmag, 1'b0};
         dout_in.rem[k] = 48'(nmag >> 1);
         dout_in.lsb[k] = nmag[0];
         dout_in.quo[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         jw_ff[0] <= '{j00: req.jac_00, j01: req.jac_01, j10: req.jac_10,
                       j11: req.jac_11, w: req.quad_weight};
         pa_ff    <= req.jac_00 * req.jac_11;
         pb_ff    <= req.jac_01 * req.jac_10;
         pr_ff[0] <= req.grad_00 * req.jac_11;
         pr_ff[1] <= req.grad_01 * req.jac_10;
         pr_ff[2] <= req.grad_01 * req.jac_00;
         pr_ff[3] <= req.grad_00 * req.jac_01;
         pr_ff[4] <= req.grad_10 * req.jac_11;
         pr_ff[5] <= req.grad_11 * req.jac_10;
         pr_ff[6] <= req.grad_11 * req.jac_00;
         pr_ff[7] <= req.grad_10 * req.jac_01;
      end
      if (en[1]) begin
         jw_ff[1]  <= jw_ff[0];
         ctl_ff[1] <= '{det: 49'(pa_ff) - 49'(pb_ff), sing: pa_ff == pb_ff,
                        sat: p_in[0].hit | p_in[1].hit | p_in[2].hit | p_in[3].hit};
         for (int k = 0; k < 4; k++) p_ff[k] <= p_in[k].val;
      end
      if (en[2]) begin
         jw_ff[2]  <= jw_ff[1];
         ctl_ff[2] <= ctl_ff[1];
         lt_ff     <= lam_s * tr_in;
         m0_ff     <= mu2_s * p_ff[0];
         m1_ff     <= mu2_s * p_ff[3];
         m2_ff     <= mu2_s * e01_in;
      end
      if (en[3]) begin
         jw_ff[3]  <= jw_ff[2];
         ctl_ff[3] <= '{det: ctl_ff[2].det, sing: ctl_ff[2].sing,
                        sat: ctl_ff[2].sat | s00_in.hit | s01_in.hit | s11_in.hit};
         s00_ff    <= s00_in.val;
         s01_ff    <= s01_in.val;
         s11_ff    <= s11_in.val;
      end
      if (en[4]) begin
         jw_ff[4]  <= jw_ff[3];
         ctl_ff[4] <= ctl_ff[3];
         sq_ff[0]  <= s00_ff * jw_ff[3].j11;
         sq_ff[1]  <= s01_ff * jw_ff[3].j01;
         sq_ff[2]  <= s01_ff * jw_ff[3].j00;
         sq_ff[3]  <= s00_ff * jw_ff[3].j10;
         sq_ff[4]  <= s01_ff * jw_ff[3].j11;
         sq_ff[5]  <= s11_ff * jw_ff[3].j01;
         sq_ff[6]  <= s11_ff * jw_ff[3].j00;
         sq_ff[7]  <= s01_ff * jw_ff[3].j10;
      end
      if (en[5]) begin
         jw_ff[5]  <= jw_ff[4];
         ctl_ff[5] <= '{det: ctl_ff[4].det, sing: ctl_ff[4].sing,
                        sat: ctl_ff[4].sat | q_in[0].hit | q_in[1].hit | q_in[2].hit
                             | q_in[3].hit};
         for (int k = 0; k < 4; k++) q_ff[k] <= q_in[k].val;
      end
      if (en[6]) begin
         ctl_ff[6] <= ctl_ff[5];
         for (int k = 0; k < 4; k++) wqp_ff[k] <= q_ff[k] * w_s;
      end
      if (en[7]) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

// ===== design/eqs_div.sv =====
module eqs_div import eqs_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STEPS-1:0]  en,
   input  div_type               din,
   output div_type               dout
);

   div_type st_ff [DIV_STEPS];

   // one restoring step per lane; the first step shifts in the numerator LSB
   function automatic div_type div_step(input div_type x, input logic first);
      div_type    o;
      logic [48:0] t;
      logic        qb;
      o = x;
      for (int l = 0; l < NUM_LANES; l++) begin
         t  = {x.rem[l], first & x.lsb[l]};
         qb = t >= {1'b0, x.dmag};
         o.rem[l] = qb ? 48'(t - {1'b0, x.dmag}) : t[DMAG_W-1:0];
         o.quo[l] = {x.quo[l][QUO_W-2:0], qb};
      end
      return o;
   endfunction

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      div_type nxt;
      if (s == 0) begin : g_first
         assign nxt = div_step(din, 1'b1);
      end else begin : g_rest
         assign nxt = div_step(st_ff[s-1], 1'b0);
      end
      always_ff @(posedge clock) begin
         if (en[s]) st_ff[s] <= nxt;
      end
   end

   assign dout = st_ff[DIV_STEPS-1];

endmodule

// ===== design/elasticity_quadrature_stress.sv =====
// Throughput: one item per cycle while rsp_stall is low; each of the 43 stages
// holds one item and collapses bubbles, the 34 one-bit divider stages make up
// most of the depth.
// Reset (synchronous, active high) empties every stage and sets
// lame_lambda and shear_modulus to 1.0.
module elasticity_quadrature_stress import eqs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_WIDTH-1:0]  csr_wdata
);

   logic [REG_WIDTH-1:0]  lam_ff, mu_ff;
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_shift;
   logic [NUM_STAGES:0]   free;
   div_type               front_out, div_out;
   rsp_payload_type       rsp_ff, rsp_in;

   always_comb begin
      free[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         free[k] = !v_ff[k] || free[k+1];
      end
   end

   assign req_stall = !free[0];
   assign v_shift   = {v_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         lam_ff <= REG_ONE;
         mu_ff  <= REG_ONE;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (free[k]) v_ff[k] <= v_shift[k];
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_LAME_LAMBDA:   lam_ff <= csr_wdata;
               CSR_SHEAR_MODULUS: mu_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   eqs_front u_front (
      .clock (clock),
      .en    (free[FRONT_STAGES-1:0]),
      .req   (req_payload),
      .lam   (lam_ff),
      .mu    (mu_ff),
      .dout  (front_out)
   );

   eqs_div u_div (
      .clock (clock),
      .en    (free[FRONT_STAGES+DIV_STEPS-1:FRONT_STAGES]),
      .din   (front_out),
      .dout  (div_out)
   );

   // round the quotient half away from zero and clamp
   always_comb begin
      logic [QUO_W-1:0]        mag, limit, m;
      logic [QUO_W:0]          inc;
      logic [NUM_LANES-1:0]    hit;
      logic [OUT_WIDTH-1:0]    val [NUM_LANES];
      for (int l = 0; l < NUM_LANES; l++) begin
         inc    = 35'(div_out.quo[l]) + 35'd1;
         mag    = inc[QUO_W:1];
         limit  = div_out.neg[l] ? 34'h080000000 : 34'h07fffffff;
         hit[l] = div_out.big[l] || (mag > limit);
         m      = hit[l] ? limit : mag;
         val[l] = div_out.neg[l] ? 32'(-m) : m[OUT_WIDTH-1:0];
      end
      if (div_out.singular) begin
         rsp_in = '0;
         rsp_in.singular_flag = 1'b1;
      end else begin
         rsp_in.res_00        = val[0];
         rsp_in.res_01        = val[1];
         rsp_in.res_10        = val[2];
         rsp_in.res_11        = val[3];
         rsp_in.singular_flag = 1'b0;
         rsp_in.overflow_flag = div_out.sat | (|hit);
      end
   end

   always_ff @(posedge clock) begin
      if (free[NUM_STAGES-1]) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = v_ff[NUM_STAGES-1];
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.singular_flag |->
         rsp_payload.res_00 == 32'sd0 && rsp_payload.res_01 == 32'sd0 &&
         rsp_payload.res_10 == 32'sd0 && rsp_payload.res_11 == 32'sd0 &&
         !rsp_payload.overflow_flag)
      else $error("singular result carries nonzero data");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v_ff[0])
      else $error("accepted item missing from first stage");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> !req_stall)
      else $error("input stalled with empty first stage");
`endif

endmodule

// ===== sim/tb_elasticity_quadrature_stress.sv =====
module tb_elasticity_quadrature_stress import eqs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 43;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LAME_LAMBDA;
   logic [REG_WIDTH-1:0] csr_wdata = '0;

   req_payload_type      pending_points[$];
   rsp_payload_type      expected_stress[$];
   logic [REG_WIDTH-1:0] lambda_reg = REG_ONE;
   logic [REG_WIDTH-1:0] mu_reg = REG_ONE;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   errors = 0;
   int                   cycles = 0;
   bit                   clamp_hit;

   elasticity_quadrature_stress DUT (.*);

   always #5 clock = ~clock;

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
      if (x > SAT_MAX) begin
         clamp_hit = 1'b1;
         return SAT_MAX;
      end
      if (x < SAT_MIN) begin
         clamp_hit = 1'b1;
         return SAT_MIN;
      end
      return x;
   endfunction

   function automatic logic signed [63:0] round_frac(input logic signed [63:0] x);
      return (x >>> FRAC_BITS) + (x[FRAC_BITS-1] ? 64'sd1 : 64'sd0);
   endfunction

   function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
      if (b > 0 && a > I64_MAX - b) begin
         clamp_hit = 1'b1;
         return I64_MAX;
      end
      if (b < 0 && a < I64_MIN - b) begin
         clamp_hit = 1'b1;
         return I64_MIN;
      end
      return a + b;
   endfunction

   function automatic logic signed [63:0] dot2(input logic signed [63:0] a, b, c, d);
      return clamp32(round_frac(add_sat64(a * b, c * d)));
   endfunction

   // num * 2^(2F) / den, round half away from zero, clamp to 32 bits
   function automatic logic signed [63:0] scaled_div(input logic signed [63:0] num,
                                                       input logic signed [63:0] den);
      logic [63:0] n, d, q, r, mag, lim;
      bit big, neg;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      big = 1'b0;
      if (d == 0) return 0;
      q = n / d;
      r = n % d;
      for (int i = 0; i < 2 * FRAC_BITS + 1; i++) begin
         if (q >= (64'd1 << 40)) begin
            big = 1'b1;
            break;
         end
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      mag = (q + 1) >> 1;
      neg = (n != 0) && ((num < 0) != (den < 0));
      lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
      if (big || mag > lim) begin
         clamp_hit = 1'b1;
         mag = lim;
      end
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic rsp_payload_type weighted_stress(input req_payload_type p);
      logic signed [63:0] g00, g01, g10, g11, j00, j01, j10, j11, w, lam, mu2;
      logic signed [63:0] det, p00, p01, p10, p11, e01, tr, s00, s01, s11;
      logic signed [63:0] q[4];
      logic signed [63:0] res[4];
      rsp_payload_type o;
      g00 = p.grad_00; g01 = p.grad_01; g10 = p.grad_10; g11 = p.grad_11;
      j00 = p.jac_00;  j01 = p.jac_01;  j10 = p.jac_10;  j11 = p.jac_11;
      w   = {40'd0, p.quad_weight};
      lam = {40'd0, lambda_reg};
      mu2 = 2 * $signed({40'd0, mu_reg});
      o = '0;
      clamp_hit = 1'b0;
      if (j00 * j11 == j01 * j10) begin
         o.singular_flag = 1'b1;
         return o;
      end
      det = add_sat64(j00 * j11, -(j01 * j10));
      p00 = dot2(g00, j11, g01, -j10);
      p01 = dot2(g00, -j01, g01, j00);
      p10 = dot2(g10, j11, g11, -j10);
      p11 = dot2(g10, -j01, g11, j00);
      e01 = (p01 + p10 + 1) >>> 1;
      tr  = p00 + p11;
      s00 = clamp32(round_frac(lam * tr + mu2 * p00));
      s11 = clamp32(round_frac(lam * tr + mu2 * p11));
      s01 = clamp32(round_frac(mu2 * e01));
      q[0] = dot2(s00, j11, s01, -j01);
      q[1] = dot2(s00, -j10, s01, j00);
      q[2] = dot2(s01, j11, s11, -j01);
      q[3] = dot2(s01, -j10, s11, j00);
      for (int k = 0; k < 4; k++)
         res[k] = scaled_div(clamp32(round_frac(q[k] * w)), det);
      o.res_00 = res[0][31:0];
      o.res_01 = res[1][31:0];
      o.res_10 = res[2][31:0];
      o.res_11 = res[3][31:0];
      o.overflow_flag = clamp_hit;
      return o;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] near(input int center, input int spread);
      return DATA_WIDTH'(center + $signed($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic req_payload_type random_point();
      req_payload_type p;
      int pick;
      pick = $urandom_range(0, 99);
      p.grad_00 = near(0, 1 << 16); p.grad_01 = near(0, 1 << 16);
      p.grad_10 = near(0, 1 << 16); p.grad_11 = near(0, 1 << 16);
      p.jac_00 = near(1 << 16, 1 << 15); p.jac_01 = near(0, 1 << 14);
      p.jac_10 = near(0, 1 << 14);       p.jac_11 = near(1 << 16, 1 << 15);
      p.quad_weight = REG_WIDTH'($urandom_range(0, 1 << 17));
      if (pick < 15) begin
         p = $bits(req_payload_type)'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom});
      end else if (pick < 25) begin
         // proportional columns: zero determinant
         p.jac_01 = $urandom_range(0, 1) ? p.jac_00 : '0;
         p.jac_11 = p.jac_01 == '0 ? '0 : p.jac_10;
      end else if (pick < 40) begin
         // big gradients, tiny determinant: drive saturation
         p.grad_00 = DATA_WIDTH'($urandom); p.grad_11 = DATA_WIDTH'($urandom);
         p.jac_00 = near(0, 64); p.jac_11 = near(0, 64);
         p.quad_weight = REG_WIDTH'($urandom);
      end
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_stress.push_back(weighted_stress(req_payload));
         if (!req_valid || !req_stall) begin
            if (pending_points.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_points.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_stall <= $urandom_range(1, 100) <= recv_stall_pct;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stress.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            rsp_payload_type e;
            e = expected_stress.pop_front();
            if (rsp_payload.res_00 !== e.res_00) begin
               $error("res_00 exp %0d got %0d", e.res_00, rsp_payload.res_00);
               errors++;
            end
            if (rsp_payload.res_01 !== e.res_01) begin
               $error("res_01 exp %0d got %0d", e.res_01, rsp_payload.res_01);
               errors++;
            end
            if (rsp_payload.res_10 !== e.res_10) begin
               $error("res_10 exp %0d got %0d", e.res_10, rsp_payload.res_10);
               errors++;
            end
            if (rsp_payload.res_11 !== e.res_11) begin
               $error("res_11 exp %0d got %0d", e.res_11, rsp_payload.res_11);
               errors++;
            end
            if (rsp_payload.singular_flag !== e.singular_flag) begin
               $error("singular_flag exp %0b got %0b", e.singular_flag,
                      rsp_payload.singular_flag);
               errors++;
            end
            if (rsp_payload.overflow_flag !== e.overflow_flag) begin
               $error("overflow_flag exp %0b got %0b", e.overflow_flag,
                      rsp_payload.overflow_flag);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic drain();
      do @(posedge clock);
      while (pending_points.size() != 0 || expected_stress.size() != 0 || req_valid);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_WIDTH-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      if (idx == CSR_LAME_LAMBDA) lambda_reg = v;
      else mu_reg = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_point(input int g00, g01, g10, g11, j00, j01, j10, j11, w);
      req_payload_type p;
      p = {DATA_WIDTH'(g00), DATA_WIDTH'(g01), DATA_WIDTH'(g10), DATA_WIDTH'(g11),
           DATA_WIDTH'(j00), DATA_WIDTH'(j01), DATA_WIDTH'(j10), DATA_WIDTH'(j11),
           REG_WIDTH'(w)};
      pending_points.push_back(p);
   endtask

   initial begin
      localparam int MX = 8388607;
      localparam int MN = -8388608;
      localparam int ONE = 65536;
      static logic [REG_WIDTH-1:0] lam_set[6] =
         '{24'd0, 24'hFFFFFF, 24'd131072, 24'd0, 24'd32768, 24'd0};
      static logic [REG_WIDTH-1:0] mu_set[6]  =
         '{24'd0, 24'hFFFFFF, 24'd32768, 24'hFFFFFF, 24'd0, 24'd0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed points at reset values
      add_point(0, 0, 0, 0, ONE, 0, 0, ONE, ONE);
      add_point(ONE, 0, 0, ONE, ONE, 0, 0, ONE, ONE);
      add_point(ONE / 2, ONE / 4, -ONE / 4, ONE / 3, 2 * ONE, ONE / 2, -ONE / 3, ONE, ONE);
      add_point(MX, MX, MX, MX, MX, MX, MX, MX, 16777215);
      add_point(MN, MN, MN, MN, MN, MN, MN, MN, 16777215);
      add_point(MX, MN, MN, MX, MX, 0, 0, MX, 16777215);
      add_point(MN, MX, MX, MN, MN, 0, 0, MX, 16777215);
      add_point(MX, MX, MN, MN, 1, 0, 0, 1, 16777215);
      add_point(MN, 0, 0, MX, 1, 0, 0, -1, 16777215);
      add_point(ONE, ONE, ONE, ONE, ONE, 0, 0, ONE, 0);
      add_point(ONE, 0, 0, ONE, 0, 0, 0, 0, ONE);
      add_point(ONE, 2, 3, ONE, ONE, ONE, ONE, ONE, ONE);
      add_point(7, 5, 3, 1, MX, MN, MN, MX, 77);
      add_point(-1, 1, -1, 1, 0, 1, 1, 0, ONE);
      add_point(1, -1, 1, -1, -ONE, ONE / 8, ONE / 8, ONE, 1);
      add_point(ONE * 64, -ONE * 64, ONE * 32, ONE * 100, 3, 1, 1, 1, 16777215);
      add_point(MX, 0, 0, 0, MX, 0, 0, 1, ONE);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) begin
            write_reg(CSR_LAME_LAMBDA, REG_WIDTH'($urandom));
            write_reg(CSR_SHEAR_MODULUS, REG_WIDTH'($urandom));
         end else begin
            write_reg(CSR_LAME_LAMBDA, lam_set[ph]);
            write_reg(CSR_SHEAR_MODULUS, mu_set[ph]);
         end
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         for (int i = 0; i < 222; i++)
            pending_points.push_back(random_point());
         drain();
      end

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
